### sv/qvr_pkg.sv
`default_nettype none

package qvr_pkg;

  // Default fractional bits of the quaternion components (Q1.14)
  localparam int QUAT_FRAC_BITS_DEF = 14;

  localparam int IN_W   = 16;             // every input and output component
  localparam int PROD_W = 2 * IN_W;       // q * v product
  localparam int P_W    = PROD_W + 1;     // sum of three q * v products
  localparam int MR_W   = P_W + IN_W;     // p * q product
  localparam int R_W    = MR_W + 2;       // sum of four p * q products

  typedef struct packed {
    logic signed [IN_W-1:0] quat_w;
    logic signed [IN_W-1:0] quat_x;
    logic signed [IN_W-1:0] quat_y;
    logic signed [IN_W-1:0] quat_z;
    logic signed [IN_W-1:0] vec_x;
    logic signed [IN_W-1:0] vec_y;
    logic signed [IN_W-1:0] vec_z;
  } in_t;

  typedef struct packed {
    logic signed [IN_W-1:0] rot_x;
    logic signed [IN_W-1:0] rot_y;
    logic signed [IN_W-1:0] rot_z;
    logic                   overflow;
  } out_t;

  typedef struct packed {
    logic signed [IN_W-1:0] w;
    logic signed [IN_W-1:0] x;
    logic signed [IN_W-1:0] y;
    logic signed [IN_W-1:0] z;
  } quat_t;

  // p = q * (v,0), full precision
  typedef struct packed {
    logic signed [P_W-1:0] w;
    logic signed [P_W-1:0] x;
    logic signed [P_W-1:0] y;
    logic signed [P_W-1:0] z;
  } pquat_t;

  // vector part of p * conj(q), before rounding
  typedef struct packed {
    logic signed [R_W-1:0] x;
    logic signed [R_W-1:0] y;
    logic signed [R_W-1:0] z;
  } rvec_t;

endpackage

`default_nettype wire

### sv/qvr_ham_left.sv
`default_nettype none

// p = q * (v,0): products in stage 1, sums in stage 2.
module qvr_ham_left
  import qvr_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   in_valid,
  input  wire in_t    operand,
  output logic        p_valid,
  output pquat_t      p,
  output quat_t       q
);

  logic                     m_valid;
  quat_t                    m_q;
  logic signed [PROD_W-1:0] xx, yy, zz;
  logic signed [PROD_W-1:0] yvz, zvy, wvx;
  logic signed [PROD_W-1:0] zvx, xvz, wvy;
  logic signed [PROD_W-1:0] xvy, yvx, wvz;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
      p_valid <= 1'b0;
    end else begin
      m_valid <= in_valid;
      p_valid <= m_valid;
    end
  end

  // stage 1: twelve 16x16 products
  always_ff @(posedge clk) begin
    m_q <= '{w: operand.quat_w, x: operand.quat_x, y: operand.quat_y, z: operand.quat_z};
    xx  <= operand.quat_x * operand.vec_x;
    yy  <= operand.quat_y * operand.vec_y;
    zz  <= operand.quat_z * operand.vec_z;
    yvz <= operand.quat_y * operand.vec_z;
    zvy <= operand.quat_z * operand.vec_y;
    wvx <= operand.quat_w * operand.vec_x;
    zvx <= operand.quat_z * operand.vec_x;
    xvz <= operand.quat_x * operand.vec_z;
    wvy <= operand.quat_w * operand.vec_y;
    xvy <= operand.quat_x * operand.vec_y;
    yvx <= operand.quat_y * operand.vec_x;
    wvz <= operand.quat_w * operand.vec_z;
  end

  // stage 2: three-term sums
  always_ff @(posedge clk) begin
    q   <= m_q;
    p.w <= -P_W'(xx) - P_W'(yy) - P_W'(zz);
    p.x <= P_W'(yvz) - P_W'(zvy) + P_W'(wvx);
    p.y <= P_W'(zvx) - P_W'(xvz) + P_W'(wvy);
    p.z <= P_W'(xvy) - P_W'(yvx) + P_W'(wvz);
  end

endmodule

`default_nettype wire

### sv/qvr_ham_right.sv
`default_nettype none

// Vector part of p * conj(q): products in stage 3, sums in stage 4.
module qvr_ham_right
  import qvr_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   p_valid,
  input  wire pquat_t p,
  input  wire quat_t  q,
  output logic        r_valid,
  output rvec_t       r
);

  logic                   m_valid;
  logic signed [MR_W-1:0] x0, x1, x2, x3;
  logic signed [MR_W-1:0] y0, y1, y2, y3;
  logic signed [MR_W-1:0] z0, z1, z2, z3;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
      r_valid <= 1'b0;
    end else begin
      m_valid <= p_valid;
      r_valid <= m_valid;
    end
  end

  // stage 3: twelve 33x16 products; conj(q) signs folded into the sums
  always_ff @(posedge clk) begin
    x0 <= p.y * q.z;
    x1 <= p.z * q.y;
    x2 <= p.x * q.w;
    x3 <= p.w * q.x;
    y0 <= p.z * q.x;
    y1 <= p.x * q.z;
    y2 <= p.y * q.w;
    y3 <= p.w * q.y;
    z0 <= p.x * q.y;
    z1 <= p.y * q.x;
    z2 <= p.z * q.w;
    z3 <= p.w * q.z;
  end

  // stage 4: four-term sums
  always_ff @(posedge clk) begin
    r.x <= R_W'(x1) - R_W'(x0) + R_W'(x2) - R_W'(x3);
    r.y <= R_W'(y1) - R_W'(y0) + R_W'(y2) - R_W'(y3);
    r.z <= R_W'(z1) - R_W'(z0) + R_W'(z2) - R_W'(z3);
  end

endmodule

`default_nettype wire

### sv/qvr_round_sat.sv
`default_nettype none

// Round half up on the shift by 2*QUAT_FRAC_BITS, saturate to 16 bits, register.
module qvr_round_sat
  import qvr_pkg::*;
#(
  parameter int QUAT_FRAC_BITS = QUAT_FRAC_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  r_valid,
  input  wire rvec_t r,
  output logic       result_valid,
  output out_t       result
);

  localparam int SH    = 2 * QUAT_FRAC_BITS;
  localparam int RND_W = ((SH + 1 > R_W) ? SH + 1 : R_W) + 1;
  localparam logic signed [RND_W-1:0] HALF = RND_W'(1) << (SH - 1);
  localparam logic signed [RND_W-1:0] MAXV = RND_W'(32767);
  localparam logic signed [RND_W-1:0] MINV = RND_W'(-32768);

  typedef struct packed {
    logic signed [IN_W-1:0] val;
    logic                   clamp;
  } sat_t;

  function automatic sat_t round_sat(input logic signed [R_W-1:0] v);
    logic signed [RND_W-1:0] s;
    logic signed [RND_W-1:0] t;
    sat_t                    o;
    s = RND_W'(v) + HALF;
    t = s >>> SH;
    if (t > MAXV) begin
      o.val   = IN_W'(MAXV);
      o.clamp = 1'b1;
    end else if (t < MINV) begin
      o.val   = IN_W'(MINV);
      o.clamp = 1'b1;
    end else begin
      o.val   = t[IN_W-1:0];
      o.clamp = 1'b0;
    end
    return o;
  endfunction

  sat_t sx, sy, sz;

  always_comb begin
    sx = round_sat(r.x);
    sy = round_sat(r.y);
    sz = round_sat(r.z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= r_valid;
    end
  end

  // stage 5: output register
  always_ff @(posedge clk) begin
    result.rot_x    <= sx.val;
    result.rot_y    <= sy.val;
    result.rot_z    <= sz.val;
    result.overflow <= sx.clamp | sy.clamp | sz.clamp;
  end

endmodule

`default_nettype wire

### sv/quaternion_vector_rotate_unit.sv
// Each accepted item passes stages 1 to 5 in order; result is the stage 5 register.
// Throughput: one item per cycle; busy is held low, the five-stage pipeline
// never stalls and the receiver cannot hold results off.
// The rate is set by the fully pipelined products and sums of the two
// Hamilton products, each cut into a multiply stage and an add stage.
// Reset (synchronous, active high) clears the valid bits; data regs are not reset.
`default_nettype none

module quaternion_vector_rotate_unit
  import qvr_pkg::*;
#(
  parameter int QUAT_FRAC_BITS = QUAT_FRAC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  input  wire in_t  operand,
  output logic      result_valid,
  output out_t      result
);

  // Pipeline map:
  //   stage 1  q * v products (twelve 16x16)
  //   stage 2  p = q * (v,0), three-term sums
  //   stage 3  p * conj(q) products (twelve 33x16)
  //   stage 4  four-term sums, full precision (no wrap possible)
  //   stage 5  round half up, saturate, overflow flag -> output register

  logic   in_valid;
  logic   p_valid;
  pquat_t p;
  quat_t  q;
  logic   r_valid;
  rvec_t  r;

  // Every stage advances every cycle, so a new item is always welcome.
  assign busy     = 1'b0;
  assign in_valid = start & ~busy;

  qvr_ham_left u_left (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .operand  (operand),
    .p_valid  (p_valid),
    .p        (p),
    .q        (q)
  );

  qvr_ham_right u_right (
    .clk     (clk),
    .rst     (rst),
    .p_valid (p_valid),
    .p       (p),
    .q       (q),
    .r_valid (r_valid),
    .r       (r)
  );

  // Shift by 2*QUAT_FRAC_BITS drops both fixed-point scalings of q.
  qvr_round_sat #(
    .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
  ) u_round (
    .clk          (clk),
    .rst          (rst),
    .r_valid      (r_valid),
    .r            (r),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

`default_nettype wire

### sim/rotate_check_pkg.sv
package rotate_check_pkg;

  import qvr_pkg::*;

  // Tracks rotations in flight through the pipeline and checks them in order.
  class rotate_scoreboard;
    int   frac_bits;
    out_t rotation_q[$];
    int   checked;
    int   saturated;
    int   errors;

    function new(int fb);
      frac_bits = fb;
      checked   = 0;
      saturated = 0;
      errors    = 0;
    endfunction

    // Round half up on the final shift, then clamp to 16 bits.
    function logic signed [IN_W-1:0] round_clamp(longint v, inout bit ovf);
      longint r;
      r = (v + (longint'(1) <<< (2 * frac_bits - 1))) >>> (2 * frac_bits);
      if (r > 32767) begin
        r   = 32767;
        ovf = 1'b1;
      end else if (r < -32768) begin
        r   = -32768;
        ovf = 1'b1;
      end
      return r[IN_W-1:0];
    endfunction

    // Vector part of q * (v,0) * conj(q), exact in 64 bits.
    function out_t predict_rotation(in_t it);
      longint qw, qx, qy, qz, vx, vy, vz;
      longint pw, px, py, pz, rx, ry, rz;
      bit     ovf;
      out_t   o;
      qw = it.quat_w; qx = it.quat_x; qy = it.quat_y; qz = it.quat_z;
      vx = it.vec_x;  vy = it.vec_y;  vz = it.vec_z;
      pw = -(qx * vx + qy * vy + qz * vz);
      px = qy * vz - qz * vy + vx * qw;
      py = qz * vx - qx * vz + vy * qw;
      pz = qx * vy - qy * vx + vz * qw;
      rx = pz * qy - py * qz + px * qw - qx * pw;
      ry = px * qz - pz * qx + py * qw - qy * pw;
      rz = py * qx - px * qy + pz * qw - qz * pw;
      ovf = 1'b0;
      o.rot_x    = round_clamp(rx, ovf);
      o.rot_y    = round_clamp(ry, ovf);
      o.rot_z    = round_clamp(rz, ovf);
      o.overflow = ovf;
      return o;
    endfunction

    function void note_input(in_t it);
      rotation_q.push_back(predict_rotation(it));
    endfunction

    function int pending();
      return rotation_q.size();
    endfunction

    function void flag(string what, longint want, longint got);
      errors++;
      if (errors <= 10)
        $display("mismatch %s: expected %0d, got %0d (result %0d)", what, want, got, checked);
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (rotation_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("result with none outstanding: %0d %0d %0d ovf %0b",
                   got.rot_x, got.rot_y, got.rot_z, got.overflow);
        return;
      end
      want = rotation_q.pop_front();
      checked++;
      if (want.overflow) saturated++;
      if (got.rot_x !== want.rot_x) flag("rot_x", want.rot_x, got.rot_x);
      if (got.rot_y !== want.rot_y) flag("rot_y", want.rot_y, got.rot_y);
      if (got.rot_z !== want.rot_z) flag("rot_z", want.rot_z, got.rot_z);
      if (got.overflow !== want.overflow) flag("overflow", want.overflow, got.overflow);
    endfunction
  endclass

endpackage

### sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import qvr_pkg::*;
  import rotate_check_pkg::*;

  localparam int FRAC      = QUAT_FRAC_BITS_DEF;
  localparam int N_RANDOM  = 1600;
  localparam int DRAIN_MAX = 1000;   // cycles allowed for the pipe to empty
  localparam int TAIL      = 10;     // extra edges after the last drain, before the summary

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  in_t  operand = '0;
  logic result_valid;
  out_t result;

  int  items_sent = 0;
  int  pauses     = 0;
  bit  idle_on    = 1'b1;

  rotate_scoreboard sb = new(FRAC);

  always #6 clk = ~clk;

  quaternion_vector_rotate_unit #(
    .QUAT_FRAC_BITS(FRAC)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .operand     (operand),
    .result_valid(result_valid),
    .result      (result)
  );

  // Monitor: note accepted items and check results at the same edge.
  // Pre-edge values are read, so nothing here races the driver.
  always @(posedge clk) begin
    if (!rst) begin
      if (start === 1'b1 && busy === 1'b0) sb.note_input(operand);
      if (result_valid === 1'b1) sb.check_result(result);
    end
  end

  // Hard stop, far beyond the slowest correct run.
  initial begin
    #2_400_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic in_t mk(int w, int x, int y, int z, int vx, int vy, int vz);
    in_t it;
    it.quat_w = w[15:0]; it.quat_x = x[15:0]; it.quat_y = y[15:0]; it.quat_z = z[15:0];
    it.vec_x = vx[15:0]; it.vec_y = vy[15:0]; it.vec_z = vz[15:0];
    return it;
  endfunction

  // Uniform in [-m, m]
  function automatic logic signed [15:0] pick_signed(int m);
    int v;
    v = int'($urandom_range(0, 2 * m)) - m;
    return v[15:0];
  endfunction

  // Boundary values mixed with the odd random one
  function automatic logic signed [15:0] pick_edge();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return -16'sd1;
      3: return 16'sd0;
      4: return 16'sd1;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_t random_item();
    in_t          it;
    int           mode;
    logic [127:0] raw;
    mode = $urandom_range(0, 9);
    raw = {$urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(in_t)-1:0];
    if (mode >= 3 && mode <= 6) begin
      // components within +-11585: scale stays within about 2x
      it.quat_w = pick_signed(11585); it.quat_x = pick_signed(11585);
      it.quat_y = pick_signed(11585); it.quat_z = pick_signed(11585);
    end else if (mode == 7 || mode == 8) begin
      // sparse: axis rotations and partial quaternions
      it.quat_w = $urandom_range(0, 1) ? pick_signed(16384) : '0;
      it.quat_x = $urandom_range(0, 1) ? pick_signed(16384) : '0;
      it.quat_y = $urandom_range(0, 1) ? pick_signed(16384) : '0;
      it.quat_z = $urandom_range(0, 1) ? pick_signed(16384) : '0;
    end else if (mode == 9) begin
      it.quat_w = pick_edge(); it.quat_x = pick_edge(); it.quat_y = pick_edge();
      it.quat_z = pick_edge(); it.vec_x = pick_edge(); it.vec_y = pick_edge();
      it.vec_z = pick_edge();
    end
    if (mode >= 3 && mode <= 8 && $urandom_range(0, 1)) begin
      it.vec_x = pick_signed(4000); it.vec_y = pick_signed(4000); it.vec_z = pick_signed(4000);
    end
    return it;
  endfunction

  // Drive one item; returns at the edge that accepts it with start still high,
  // so a back-to-back item needs no second assignment in that step.
  task automatic send_item(input in_t it);
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    operand <= it;
    do @(posedge clk); while (busy !== 1'b0);
    items_sent++;
  endtask

  // Sender drops start and waits until every outstanding rotation has come back or the drain limit is reached.
  task automatic wait_empty();
    int n;
    start <= 1'b0;
    n = 0;
    do begin
      @(posedge clk);
      n++;
    end while (sb.pending() != 0 && n < DRAIN_MAX);
  endtask

  initial begin
    in_t directed[$];

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    directed.push_back(mk(0, 0, 0, 0, 32767, -32768, 1));           // zero quaternion
    directed.push_back(mk(16384, 0, 0, 0, 1000, -2000, 3000));      // identity
    directed.push_back(mk(16384, 0, 0, 0, 32767, -32768, -1));
    directed.push_back(mk(16384, 0, 0, 0, -1, -1, -1));
    directed.push_back(mk(8192, 0, 0, 0, 2, -2, 6));                // exact halves, ties go up
    directed.push_back(mk(-8192, 0, 0, 0, -6, 10, -10));
    directed.push_back(mk(-32768, 0, 0, 0, 32767, 32767, 32767));   // clamp high
    directed.push_back(mk(-32768, 0, 0, 0, -32768, -32768, -32768));// clamp low
    directed.push_back(mk(-32768, 0, 0, 0, 8191, -8192, 8192));     // clamp on one axis only
    directed.push_back(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767));
    directed.push_back(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
    directed.push_back(mk(-32768, 32767, -32768, 32767, -32768, 32767, -32768));
    directed.push_back(mk(0, 16384, 0, 0, 100, 200, 300));          // half turns
    directed.push_back(mk(0, 0, 16384, 0, 100, 200, 300));
    directed.push_back(mk(0, 0, 0, 16384, 100, 200, 300));
    directed.push_back(mk(11585, 0, 0, 11585, 10000, 0, 0));        // quarter turns
    directed.push_back(mk(11585, 11585, 0, 0, 0, 10000, 0));
    directed.push_back(mk(11585, 0, -11585, 0, 0, 0, -10000));
    directed.push_back(mk(8192, 8192, 8192, 8192, 30000, -20000, 5000));
    directed.push_back(mk(32767, 0, 0, 0, 8191, -8192, 8192));      // non-unit, ~4x scale
    directed.push_back(mk(32767, -32768, 32767, -32768, 0, 0, 0));  // zero vector
    directed.push_back(mk(1, 1, 1, 1, 1, 1, 1));
    directed.push_back(mk(-1, -1, -1, -1, -32768, 32767, -32768));

    foreach (directed[i]) send_item(directed[i]);
    wait_empty();
    pauses++;

    for (int i = 0; i < N_RANDOM; i++) begin
      if ($urandom_range(0, 63) == 0) idle_on = ~idle_on;
      send_item(random_item());
      if (i == N_RANDOM / 2 || $urandom_range(0, 399) == 0) begin
        wait_empty();
        pauses++;
      end
    end

    // wait_empty drops start itself
    wait_empty();
    repeat (TAIL) @(posedge clk);

    $display("Sent %0d items (%0d directed), %0d results checked, %0d saturated.",
             items_sent, directed.size(), sb.checked, sb.saturated);
    $display("Sender drained the pipe %0d times; %0d errors, %0d left outstanding.",
             pauses, sb.errors, sb.pending());
    if (sb.errors == 0 && sb.pending() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
